// ===== rtl/core/prtt_pkg.sv =====
// ----------------------------------------------------------------------------
// prtt_pkg
// Operation and status codes, controller command and datapath status types
// for the pending request timeout table.
// ----------------------------------------------------------------------------
package prtt_pkg;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_REMOVE  = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;
	localparam logic [1:0] OP_PURGE   = 2'd3;

	localparam logic [3:0] ST_INSERTED     = 4'd0;
	localparam logic [3:0] ST_DUPLICATE    = 4'd1;
	localparam logic [3:0] ST_FULL         = 4'd2;
	localparam logic [3:0] ST_REMOVED      = 4'd3;
	localparam logic [3:0] ST_NOT_FOUND    = 4'd4;
	localparam logic [3:0] ST_EXPIRED      = 4'd5;
	localparam logic [3:0] ST_NONE_EXPIRED = 4'd6;
	localparam logic [3:0] ST_PURGED       = 4'd7;
	localparam logic [3:0] ST_NONE_PURGED  = 4'd8;

	typedef struct packed {
		logic cap;
		logic scan;
		logic ins_fin;
		logic rem_fin;
		logic rd_oldest;
		logic to_none;
		logic to_pop;
		logic pg_start;
		logic pg_rd;
		logic pg_step;
		logic pg_fin;
	} prtt_cmd_t;

	typedef struct packed {
		logic scan_busy;
		logic out_free;
		logic to_expired;
		logic rd_conn_nz;
		logic pg_empty;
		logic pg_hit;
		logic held_v;
		logic pg_end;
	} prtt_stat_t;

endpackage

// ===== rtl/core/prtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// prtt_ctrl
// Sequencer: id scan, timeout pop loop and purge walk.
// ----------------------------------------------------------------------------
module prtt_ctrl
	import prtt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] operation,
	output logic       in_stall,
	input  prtt_stat_t st,
	output prtt_cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_SCAN     = 9'b000000010,
		S_DECIDE   = 9'b000000100,
		S_TO_RD    = 9'b000001000,
		S_TO_EVAL  = 9'b000010000,
		S_PG_START = 9'b000100000,
		S_PG_RD    = 9'b001000000,
		S_PG_EVAL  = 9'b010000000,
		S_PG_FIN   = 9'b100000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] op_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					unique case (operation)
						OP_INSERT, OP_REMOVE: state_d = S_SCAN;
						OP_TIMEOUT:           state_d = S_TO_RD;
						default:              state_d = S_PG_START;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (!st.scan_busy) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (st.out_free) begin
					if (op_q == OP_INSERT) cmd.ins_fin = 1'b1;
					else                   cmd.rem_fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_TO_RD: begin
				cmd.rd_oldest = 1'b1;
				state_d       = S_TO_EVAL;
			end
			S_TO_EVAL: begin
				cmd.rd_oldest = 1'b1;
				if (!st.to_expired) begin
					if (st.out_free) begin
						cmd.to_none = 1'b1;
						state_d     = S_IDLE;
					end
				end else if (st.rd_conn_nz) begin
					if (st.out_free) begin
						cmd.to_pop = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					cmd.to_pop = 1'b1;
					state_d    = S_TO_RD;
				end
			end
			S_PG_START: begin
				if (st.pg_empty) begin
					state_d = S_PG_FIN;
				end else begin
					cmd.pg_start = 1'b1;
					state_d      = S_PG_RD;
				end
			end
			S_PG_RD: begin
				cmd.pg_rd = 1'b1;
				state_d   = S_PG_EVAL;
			end
			S_PG_EVAL: begin
				if (!(st.pg_hit && st.held_v && !st.out_free)) begin
					cmd.pg_step = 1'b1;
					state_d     = st.pg_end ? S_PG_FIN : S_PG_RD;
				end
			end
			S_PG_FIN: begin
				if (st.out_free) begin
					cmd.pg_fin = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_INSERT;
		end else begin
			state_q <= state_d;
			if (cmd.cap) op_q <= operation;
		end
	end

endmodule

// ===== rtl/core/prtt_dp.sv =====
// ----------------------------------------------------------------------------
// prtt_dp
// Entry memories, list pointers, scan and walk registers, result register.
// ----------------------------------------------------------------------------
module prtt_dp
	import prtt_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  prtt_cmd_t   cmd,
	output prtt_stat_t  st,
	input  logic [31:0] request_id,
	input  logic [7:0]  connection_tag,
	input  logic [15:0] dispatch_tag,
	input  logic [31:0] expire_time,
	input  logic [31:0] current_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [31:0] out_request_id,
	output logic [7:0]  out_connection,
	output logic [15:0] out_dispatch,
	output logic [31:0] next_expire,
	output logic        next_valid,
	output logic        last_result
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OW = $clog2(CAPACITY + 1);
	localparam logic [OW-1:0] CAP_W = OW'(CAPACITY);

	logic [31:0] ident_mem [CAPACITY];
	logic [7:0]  conn_mem  [CAPACITY];
	logic [15:0] tag_mem   [CAPACITY];
	logic [31:0] dl_mem    [CAPACITY];
	logic [IW-1:0] older_mem [CAPACITY];
	logic [IW-1:0] newer_mem [CAPACITY];

	logic [CAPACITY-1:0] used_q;
	logic [IW-1:0] oldest_q, newest_q;
	logic [OW-1:0] occ_q;

	logic [31:0] id_q, exp_q, now_q;
	logic [7:0]  conn_q;
	logic [15:0] disp_q;

	logic [31:0]   rd_ident_q, rd_dl_q;
	logic [7:0]    rd_conn_q;
	logic [15:0]   rd_tag_q;
	logic [IW-1:0] rd_older_q, rd_newer_q, rd_slot_q, rd_addr;

	logic [OW-1:0] cnt_q;
	logic          scan_v_s1;
	logic          m_found_q, free_found_q;
	logic [IW-1:0] m_slot_q, m_older_q, m_newer_q, free_slot_q;
	logic [15:0]   m_tag_q;

	logic [IW-1:0] walk_q;
	logic [OW-1:0] pn_q;
	logic          held_v_q;
	logic [31:0]   held_id_q;
	logic [7:0]    held_conn_q;
	logic [15:0]   held_tag_q;

	logic          scan_issue, unl, mid, ins_ok, pg_hit;
	logic [IW-1:0] us, uo, un, oldest_d, newest_d;

	logic          older_we, newer_we, conn_we;
	logic [IW-1:0] older_wa, older_wd, newer_wa, newer_wd, conn_wa;
	logic [7:0]    conn_wd;

	logic          push, p_nv, p_last;
	logic [3:0]    p_status;
	logic [31:0]   p_id, p_next;
	logic [7:0]    p_conn;
	logic [15:0]   p_disp;

	assign scan_issue = cmd.scan && (cnt_q < CAP_W);
	assign pg_hit     = (rd_conn_q == conn_q);

	always_comb begin
		if (scan_issue)         rd_addr = cnt_q[IW-1:0];
		else if (cmd.rd_oldest) rd_addr = oldest_q;
		else                    rd_addr = walk_q;
	end

	assign st.scan_busy  = (cnt_q < CAP_W) || scan_v_s1;
	assign st.out_free   = !out_valid || !out_stall;
	assign st.to_expired = (occ_q != '0) && !(rd_dl_q > now_q);
	assign st.rd_conn_nz = (rd_conn_q != 8'd0);
	assign st.pg_empty   = (conn_q == 8'd0) || (occ_q == '0);
	assign st.pg_hit     = pg_hit;
	assign st.held_v     = held_v_q;
	assign st.pg_end     = ((pn_q + OW'(1)) == occ_q);

	assign ins_ok = cmd.ins_fin && !m_found_q && free_found_q && (occ_q < CAP_W);
	assign unl    = (cmd.rem_fin && m_found_q) || cmd.to_pop;

	always_comb begin
		us       = cmd.to_pop ? rd_slot_q  : m_slot_q;
		uo       = cmd.to_pop ? rd_older_q : m_older_q;
		un       = cmd.to_pop ? rd_newer_q : m_newer_q;
		oldest_d = oldest_q;
		newest_d = newest_q;
		mid      = 1'b0;
		if (occ_q <= OW'(1)) begin
			oldest_d = '0;
			newest_d = '0;
		end else if (us == newest_q) begin
			newest_d = uo;
		end else if (us == oldest_q) begin
			oldest_d = un;
		end else begin
			mid = 1'b1;
		end
	end

	always_comb begin
		older_we = (ins_ok && occ_q != '0) || (unl && mid);
		older_wa = ins_ok ? free_slot_q : un;
		older_wd = ins_ok ? newest_q    : uo;
		newer_we = older_we;
		newer_wa = ins_ok ? newest_q    : uo;
		newer_wd = ins_ok ? free_slot_q : un;
		conn_we  = ins_ok || (cmd.pg_step && pg_hit);
		conn_wa  = ins_ok ? free_slot_q : walk_q;
		conn_wd  = ins_ok ? conn_q : 8'd0;
	end

	always_ff @(posedge clk) begin
		if (ins_ok) begin
			ident_mem[free_slot_q] <= id_q;
			tag_mem[free_slot_q]   <= disp_q;
			dl_mem[free_slot_q]    <= exp_q;
		end
		if (conn_we)  conn_mem[conn_wa]   <= conn_wd;
		if (older_we) older_mem[older_wa] <= older_wd;
		if (newer_we) newer_mem[newer_wa] <= newer_wd;
		rd_ident_q <= ident_mem[rd_addr];
		rd_conn_q  <= conn_mem[rd_addr];
		rd_tag_q   <= tag_mem[rd_addr];
		rd_dl_q    <= dl_mem[rd_addr];
		rd_older_q <= older_mem[rd_addr];
		rd_newer_q <= newer_mem[rd_addr];
		rd_slot_q  <= rd_addr;
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			id_q   <= request_id;
			conn_q <= connection_tag;
			disp_q <= dispatch_tag;
			exp_q  <= expire_time;
			now_q  <= current_time;
		end
		if (scan_v_s1 && used_q[rd_slot_q] && rd_ident_q == id_q && !m_found_q) begin
			m_slot_q  <= rd_slot_q;
			m_tag_q   <= rd_tag_q;
			m_older_q <= rd_older_q;
			m_newer_q <= rd_newer_q;
		end
		if (scan_v_s1 && !used_q[rd_slot_q] && !free_found_q) free_slot_q <= rd_slot_q;
		if (cmd.pg_start) begin
			walk_q <= newest_q;
			pn_q   <= '0;
		end else if (cmd.pg_step) begin
			walk_q <= rd_older_q;
			pn_q   <= pn_q + OW'(1);
		end
		if (cmd.pg_step && pg_hit) begin
			held_id_q   <= rd_ident_q;
			held_conn_q <= rd_conn_q;
			held_tag_q  <= rd_tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= CAP_W;
			scan_v_s1    <= 1'b0;
			m_found_q    <= 1'b0;
			free_found_q <= 1'b0;
			held_v_q     <= 1'b0;
			used_q       <= '0;
			oldest_q     <= '0;
			newest_q     <= '0;
			occ_q        <= '0;
		end else begin
			scan_v_s1 <= scan_issue;
			if (cmd.cap) begin
				cnt_q        <= '0;
				m_found_q    <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (scan_issue) cnt_q <= cnt_q + OW'(1);
				if (scan_v_s1 && used_q[rd_slot_q] && rd_ident_q == id_q) m_found_q <= 1'b1;
				if (scan_v_s1 && !used_q[rd_slot_q]) free_found_q <= 1'b1;
			end
			if (cmd.pg_start || cmd.pg_fin) held_v_q <= 1'b0;
			else if (cmd.pg_step && pg_hit) held_v_q <= 1'b1;
			if (ins_ok) begin
				used_q[free_slot_q] <= 1'b1;
				if (occ_q == '0) oldest_q <= free_slot_q;
				newest_q <= free_slot_q;
				occ_q    <= occ_q + OW'(1);
			end else if (unl) begin
				used_q[us] <= 1'b0;
				oldest_q   <= oldest_d;
				newest_q   <= newest_d;
				if (occ_q != '0) occ_q <= occ_q - OW'(1);
			end
		end
	end

	always_comb begin
		push     = 1'b0;
		p_status = ST_INSERTED;
		p_id     = '0;
		p_conn   = '0;
		p_disp   = '0;
		p_next   = '0;
		p_nv     = 1'b0;
		p_last   = 1'b1;
		if (cmd.ins_fin) begin
			push = 1'b1;
			if (m_found_q)    p_status = ST_DUPLICATE;
			else if (!ins_ok) p_status = ST_FULL;
		end else if (cmd.rem_fin) begin
			push = 1'b1;
			if (m_found_q) begin
				p_status = ST_REMOVED;
				p_id     = id_q;
				p_disp   = m_tag_q;
			end else begin
				p_status = ST_NOT_FOUND;
			end
		end else if (cmd.to_none) begin
			push     = 1'b1;
			p_status = ST_NONE_EXPIRED;
			p_nv     = (occ_q != '0);
			p_next   = p_nv ? rd_dl_q : 32'd0;
		end else if (cmd.to_pop && rd_conn_q != 8'd0) begin
			push     = 1'b1;
			p_status = ST_EXPIRED;
			p_id     = rd_ident_q;
			p_conn   = rd_conn_q;
			p_disp   = rd_tag_q;
		end else if ((cmd.pg_step && pg_hit && held_v_q) || (cmd.pg_fin && held_v_q)) begin
			push     = 1'b1;
			p_status = ST_PURGED;
			p_id     = held_id_q;
			p_conn   = held_conn_q;
			p_disp   = held_tag_q;
			p_last   = cmd.pg_fin;
		end else if (cmd.pg_fin) begin
			push     = 1'b1;
			p_status = ST_NONE_PURGED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (push) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			status         <= p_status;
			out_request_id <= p_id;
			out_connection <= p_conn;
			out_dispatch   <= p_disp;
			next_expire    <= p_next;
			next_valid     <= p_nv;
			last_result    <= p_last;
		end
	end

endmodule

// ===== rtl/core/pending_request_timeout_table_core.sv =====
// ----------------------------------------------------------------------------
// pending_request_timeout_table_core
// Outstanding request table in insertion order with id lookup, timeout pop
// and purge by connection.
//
// channel   signals                                 direction
// request   in_valid/in_stall + six request fields  in
// result    out_valid/out_stall + seven fields      out
//
// Insert and remove scan every slot.
// Timeout check silently pops expired purged entries, then reports; purge
// walks every entry.
// Entry memories have a registered read port; each list hop waits for it.
// Reset clears valid bits and list pointers only; no clearing pass.
// A result holds while out_stall is high; the walk waits when it must emit.
// ----------------------------------------------------------------------------
module pending_request_timeout_table_core
	import prtt_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] request_id,
	input  logic [7:0]  connection_tag,
	input  logic [15:0] dispatch_tag,
	input  logic [31:0] expire_time,
	input  logic [31:0] current_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [31:0] out_request_id,
	output logic [7:0]  out_connection,
	output logic [15:0] out_dispatch,
	output logic [31:0] next_expire,
	output logic        next_valid,
	output logic        last_result
);

	prtt_cmd_t  cmd;
	prtt_stat_t st;

	prtt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.st        (st),
		.cmd       (cmd)
	);

	prtt_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.request_id     (request_id),
		.connection_tag (connection_tag),
		.dispatch_tag   (dispatch_tag),
		.expire_time    (expire_time),
		.current_time   (current_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.out_request_id (out_request_id),
		.out_connection (out_connection),
		.out_dispatch   (out_dispatch),
		.next_expire    (next_expire),
		.next_valid     (next_valid),
		.last_result    (last_result)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted request without going busy");

	a_no_held_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !st.held_v)
		else $error("purge result left behind");

	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pg_fin || cmd.ins_fin || cmd.rem_fin || cmd.to_none) |-> st.out_free)
		else $error("result pushed over a waiting one");

endmodule
